>>> hw/rtl/prime_subset_sorter_macros.svh
// assertion macros for the rtl
`ifndef PRIME_SUBSET_SORTER_MACROS_SVH
`define PRIME_SUBSET_SORTER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// when ante holds, cons must hold in the following cycle
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/pss_pkg.sv
`default_nettype none

package pss_pkg;

  localparam int unsigned MAX_ITEMS_DEF  = 64;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // read address source of the element memory
  typedef enum logic [1:0] {
    RS_K = 2'd0,
    RS_I = 2'd1,
    RS_J = 2'd2
  } rsel_e;

  typedef struct packed {
    logic  load;
    logic  k_clr;
    logic  k_inc;
    logic  i_clr;
    logic  i_inc;
    logic  j_set;
    logic  j_inc;
    logic  n_load;
    logic  d_step;
    logic  div_start;
    logic  mark_set;
    logic  mark_val;
    logic  we_mark;
    logic  cur_load;
    logic  swap;
    logic  we_i;
    logic  out_load;
    logic  list_clr;
    rsel_e rsel;
  } cmd_t;

  typedef struct packed {
    logic val_lt2;
    logic val_lt4;
    logic val_even;
    logic sq_gt_n;
    logic div_done;
    logic rem_zero;
    logic k_last;
    logic i_last;
    logic j_last;
    logic cnt_one;
    logic swap_ok;
  } st_t;

endpackage

`default_nettype wire

>>> hw/rtl/pss_if.sv
`default_nettype none

interface pss_in_if #(
  parameter int unsigned VALUE_BITS = pss_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

interface pss_out_if #(
  parameter int unsigned VALUE_BITS = pss_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value_out;
  logic                         last_out;
  logic                         overflow;

  modport source (output valid, output value_out, output last_out, output overflow,
                  input ready);
  modport sink (input valid, input value_out, input last_out, input overflow,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pss_rem.sv
`default_nettype none

// restoring remainder unit, one dividend bit per cycle
module pss_rem #(
  parameter int unsigned VALUE_BITS = pss_pkg::VALUE_BITS_DEF,
  parameter int unsigned DW         = VALUE_BITS / 2 + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [VALUE_BITS-1:0] dividend_i,
  input  wire logic [DW-1:0]         divisor_i,
  output logic                       done_o,
  output logic                       rem_zero_o
);

  localparam int unsigned IW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [VALUE_BITS-1:0] sh_q, sh_d;
  logic [DW-1:0]         rem_q, rem_d;
  logic [DW:0]           trial;
  logic [DW:0]           diff;

  assign trial = {rem_q, sh_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    idx_d  = idx_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = IW'(VALUE_BITS - 1);
      sh_d   = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      sh_d = sh_q << 1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[DW-1:0];
      end else begin
        rem_d = trial[DW-1:0];
      end
      if (idx_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        idx_d = idx_q - IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

`default_nettype wire

>>> hw/rtl/pss_dpath.sv
`default_nettype none

module pss_dpath #(
  parameter int unsigned MAX_ITEMS  = pss_pkg::MAX_ITEMS_DEF,
  parameter int unsigned VALUE_BITS = pss_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pss_pkg::cmd_t         cmd_i,
  output pss_pkg::st_t               st_o,
  input  wire logic [VALUE_BITS-1:0] in_value_i,
  output logic [VALUE_BITS-1:0]      out_value_o,
  output logic                       out_last_o,
  output logic                       overflow_o
);

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned MW = VB + 1;
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned DW = VB / 2 + 1;
  localparam int unsigned SW = VB + 1;

  // element memory, each word holds {prime mark, value}
  logic [MW-1:0] mem_q [MAX_ITEMS];
  logic [MW-1:0] rd_q;
  logic [AW-1:0] raddr, waddr;
  logic [MW-1:0] wdata;
  logic          we;

  logic [CW-1:0] cnt_q;
  logic          ovf_q;
  logic [AW-1:0] k_q, i_q, j_q;
  logic [VB-1:0] n_q;
  logic [DW-1:0] d_q;
  logic [SW-1:0] sq_q;
  logic          mark_q;
  logic [MW-1:0] cur_q;
  logic [VB-1:0] out_val_q;
  logic          out_last_q;
  logic          full;
  logic [VB-1:0] rd_val;
  logic          div_done, rem_zero;

  assign full   = (cnt_q == CW'(MAX_ITEMS));
  assign rd_val = rd_q[VB-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[AW-1:0];
    wdata = {1'b0, in_value_i};
    if (cmd_i.load && !full) begin
      we = 1'b1;
    end else if (cmd_i.we_mark) begin
      we    = 1'b1;
      waddr = k_q;
      wdata = {mark_q, n_q};
    end else if (cmd_i.swap) begin
      we    = 1'b1;
      waddr = j_q;
      wdata = cur_q;
    end else if (cmd_i.we_i) begin
      we    = 1'b1;
      waddr = i_q;
      wdata = cur_q;
    end
  end

  always_comb begin
    case (cmd_i.rsel)
      pss_pkg::RS_K: raddr = k_q;
      pss_pkg::RS_I: raddr = i_q;
      pss_pkg::RS_J: raddr = j_q;
      default:       raddr = k_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      k_q   <= '0;
      i_q   <= '0;
      j_q   <= '0;
    end else begin
      if (cmd_i.list_clr) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + AW'(1);
      end
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + AW'(1);
      end
      if (cmd_i.j_set) begin
        j_q <= i_q + AW'(1);
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.n_load) begin
      n_q  <= rd_val;
      d_q  <= DW'(3);
      sq_q <= SW'(9);
    end else if (cmd_i.d_step) begin
      // (d + 2)^2 = d^2 + 4d + 4
      d_q  <= d_q + DW'(2);
      sq_q <= sq_q + SW'({d_q, 2'b00}) + SW'(4);
    end
    if (cmd_i.mark_set) begin
      mark_q <= cmd_i.mark_val;
    end
    if (cmd_i.cur_load) begin
      cur_q <= rd_q;
    end else if (cmd_i.swap) begin
      cur_q <= {cur_q[VB], rd_val};
    end
    if (cmd_i.out_load) begin
      out_val_q  <= rd_val;
      out_last_q <= st_o.k_last;
    end
  end

  pss_rem #(
    .VALUE_BITS(VB),
    .DW        (DW)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .done_o    (div_done),
    .rem_zero_o(rem_zero)
  );

  always_comb begin
    st_o.val_lt2  = $signed(rd_val) < $signed(VB'(2));
    st_o.val_lt4  = $signed(rd_val) < $signed(VB'(4));
    st_o.val_even = ~rd_val[0];
    st_o.sq_gt_n  = sq_q > {1'b0, n_q};
    st_o.div_done = div_done;
    st_o.rem_zero = rem_zero;
    st_o.k_last   = (CW'(k_q) + CW'(1)) == cnt_q;
    st_o.i_last   = (CW'(i_q) + CW'(2)) == cnt_q;
    st_o.j_last   = (CW'(j_q) + CW'(1)) == cnt_q;
    st_o.cnt_one  = cnt_q == CW'(1);
    st_o.swap_ok  = cur_q[VB] && rd_q[VB] && ($signed(cur_q[VB-1:0]) > $signed(rd_val));
  end

  assign out_value_o = out_val_q;
  assign out_last_o  = out_last_q;
  assign overflow_o  = ovf_q;

endmodule

`default_nettype wire

>>> hw/rtl/pss_ctrl.sv
`default_nettype none
`include "prime_subset_sorter_macros.svh"

module pss_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pss_pkg::st_t  st_i,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  input  wire logic          out_ready_i,
  output pss_pkg::cmd_t      cmd_o,
  output logic               in_ready_o,
  output logic               out_valid_o
);

  typedef enum logic [13:0] {
    ST_LOAD  = 14'h0001,
    ST_PRD   = 14'h0002,
    ST_PLAT  = 14'h0004,
    ST_PTEST = 14'h0008,
    ST_PDIV  = 14'h0010,
    ST_PWR   = 14'h0020,
    ST_SRDI  = 14'h0040,
    ST_SLATI = 14'h0080,
    ST_SRDJ  = 14'h0100,
    ST_SCMP  = 14'h0200,
    ST_SWRI  = 14'h0400,
    ST_ERD   = 14'h0800,
    ST_ELAT  = 14'h1000,
    ST_EOUT  = 14'h2000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rsel  = pss_pkg::RS_K;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.k_clr = 1'b1;
            state_d     = ST_PRD;
          end
        end
      end
      ST_PRD: begin
        cmd_o.rsel = pss_pkg::RS_K;
        state_d    = ST_PLAT;
      end
      ST_PLAT: begin
        cmd_o.n_load = 1'b1;
        if (st_i.val_lt2) begin
          cmd_o.mark_set = 1'b1;
          cmd_o.mark_val = 1'b0;
          state_d        = ST_PWR;
        end else if (st_i.val_lt4) begin
          cmd_o.mark_set = 1'b1;
          cmd_o.mark_val = 1'b1;
          state_d        = ST_PWR;
        end else if (st_i.val_even) begin
          cmd_o.mark_set = 1'b1;
          cmd_o.mark_val = 1'b0;
          state_d        = ST_PWR;
        end else begin
          state_d = ST_PTEST;
        end
      end
      ST_PTEST: begin
        // no odd divisor up to the square root
        if (st_i.sq_gt_n) begin
          cmd_o.mark_set = 1'b1;
          cmd_o.mark_val = 1'b1;
          state_d        = ST_PWR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (st_i.div_done) begin
          if (st_i.rem_zero) begin
            cmd_o.mark_set = 1'b1;
            cmd_o.mark_val = 1'b0;
            state_d        = ST_PWR;
          end else begin
            cmd_o.d_step = 1'b1;
            state_d      = ST_PTEST;
          end
        end
      end
      ST_PWR: begin
        cmd_o.we_mark = 1'b1;
        if (st_i.k_last) begin
          cmd_o.k_clr = 1'b1;
          if (st_i.cnt_one) begin
            state_d = ST_ERD;
          end else begin
            cmd_o.i_clr = 1'b1;
            state_d     = ST_SRDI;
          end
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_PRD;
        end
      end
      ST_SRDI: begin
        cmd_o.rsel = pss_pkg::RS_I;
        state_d    = ST_SLATI;
      end
      ST_SLATI: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.j_set    = 1'b1;
        state_d        = ST_SRDJ;
      end
      ST_SRDJ: begin
        cmd_o.rsel = pss_pkg::RS_J;
        state_d    = ST_SCMP;
      end
      ST_SCMP: begin
        cmd_o.swap = st_i.swap_ok;
        if (st_i.j_last) begin
          state_d = ST_SWRI;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = ST_SRDJ;
        end
      end
      ST_SWRI: begin
        cmd_o.we_i = 1'b1;
        if (st_i.i_last) begin
          state_d = ST_ERD;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = ST_SRDI;
        end
      end
      ST_ERD: begin
        cmd_o.rsel = pss_pkg::RS_K;
        state_d    = ST_ELAT;
      end
      ST_ELAT: begin
        cmd_o.out_load = 1'b1;
        state_d        = ST_EOUT;
      end
      ST_EOUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (st_i.k_last) begin
            cmd_o.list_clr = 1'b1;
            cmd_o.k_clr    = 1'b1;
            state_d        = ST_LOAD;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  `PSS_ASSERT(a_state_onehot, $onehot(state_q), "controller state not one-hot")
  `PSS_ASSERT(a_no_overlap, in_ready_o |-> !out_valid_o, "input taken while emitting")
  `PSS_ASSERT_NEXT(a_div_wait, cmd_o.div_start, state_q == ST_PDIV, "divider start lost")
  `PSS_ASSERT_NEXT(a_list_end, (state_q == ST_EOUT) && out_ready_i && st_i.k_last, state_q == ST_LOAD, "list did not end after last item")

endmodule

`default_nettype wire

>>> hw/rtl/prime_subset_sorter.sv
// input: one item per cycle while loading; input stalls from the last item until
//   the final result is taken
// prime test: each element is read, latched, marked and written back; odd values above
//   3 are tried on odd divisors up to the square root by the bit-serial remainder unit
// sort: pass per item i, comparing each later item; emission: read, latch, offer result
// reset clears the controller, element count and overflow flag; memory is not cleared
`default_nettype none

module prime_subset_sorter #(
  parameter int unsigned MAX_ITEMS  = pss_pkg::MAX_ITEMS_DEF,
  parameter int unsigned VALUE_BITS = pss_pkg::VALUE_BITS_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  pss_in_if.sink    in_i,
  pss_out_if.source out_o
);

  pss_pkg::cmd_t         cmd;
  pss_pkg::st_t          st;
  logic [VALUE_BITS-1:0] out_value;

  pss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .st_i       (st),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.is_last),
    .out_ready_i(out_o.ready),
    .cmd_o      (cmd),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid)
  );

  pss_dpath #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .in_value_i (in_i.value),
    .out_value_o(out_value),
    .out_last_o (out_o.last_out),
    .overflow_o (out_o.overflow)
  );

  assign out_o.value_out = out_value;

endmodule

`default_nettype wire
